// File: src/ioj_pkg.sv
// Package for the IMU orientation and jitter qualifier.
// Holds payload structs, face and register codes, widths and reset values.
// No dependencies.
package ioj_pkg;

	localparam int ACCEL_WIDTH  = 16;
	localparam int GYRO_WIDTH   = 16;
	localparam int ACC_THR_W    = 15;
	localparam int JIT_THR_W    = 16;
	localparam int COUNT_W      = 8;
	localparam int CFG_INDEX_W  = 3;
	localparam int CFG_DATA_W   = 16;

	// magnitude compare widths
	localparam int ACMP_W  = (ACCEL_WIDTH > ACC_THR_W) ? ACCEL_WIDTH : ACC_THR_W;
	localparam int GDIFF_W = GYRO_WIDTH + 1;
	localparam int GCMP_W  = (GDIFF_W > JIT_THR_W) ? GDIFF_W : JIT_THR_W;

	typedef enum logic [2:0] {
		FACE_UP    = 3'd0,
		FACE_DOWN  = 3'd1,
		FACE_LEFT  = 3'd2,
		FACE_RIGHT = 3'd3,
		FACE_FRONT = 3'd4,
		FACE_BACK  = 3'd5,
		FACE_IDLE  = 3'd6
	} face_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_ACCEL_HIGH   = 3'd0,
		CFG_ACCEL_LOW    = 3'd1,
		CFG_JITTER_THR   = 3'd2,
		CFG_STILL_TARGET = 3'd3,
		CFG_JITTER_WIN   = 3'd4,
		CFG_JITTER_MIN   = 3'd5
	} cfg_reg_t;

	localparam logic [ACC_THR_W-1:0] RST_ACCEL_HIGH   = 15'd8800;
	localparam logic [ACC_THR_W-1:0] RST_ACCEL_LOW    = 15'd2000;
	localparam logic [JIT_THR_W-1:0] RST_JITTER_THR   = 16'd800;
	localparam logic [COUNT_W-1:0]   RST_STILL_TARGET = 8'd50;
	localparam logic [COUNT_W-1:0]   RST_JITTER_WIN   = 8'd20;
	localparam logic [COUNT_W-1:0]   RST_JITTER_MIN   = 8'd10;

	typedef struct packed {
		logic [ACC_THR_W-1:0] accel_high_threshold;
		logic [ACC_THR_W-1:0] accel_low_threshold;
		logic [JIT_THR_W-1:0] jitter_threshold;
		logic [COUNT_W-1:0]   still_count_target;
		logic [COUNT_W-1:0]   jitter_window;
		logic [COUNT_W-1:0]   jitter_min_count;
	} cfg_t;

	typedef struct packed {
		logic signed [ACCEL_WIDTH-1:0] accel_x;
		logic signed [ACCEL_WIDTH-1:0] accel_y;
		logic signed [ACCEL_WIDTH-1:0] accel_z;
		logic signed [GYRO_WIDTH-1:0]  gyro_x;
		logic signed [GYRO_WIDTH-1:0]  gyro_y;
		logic signed [GYRO_WIDTH-1:0]  gyro_z;
	} imu_sample_t;

	typedef struct packed {
		face_t raw_face;
		face_t stable_face;
		logic  jitter_flag;
		logic  accepted;
	} imu_result_t;

endpackage

// File: src/imu_orientation_jitter_qualifier.sv
// IMU orientation and jitter qualifier, top level.
// Depends on ioj_pkg, ioj_jitter, ioj_classify, ioj_still.
//
// Usage:
//   in_*  : one IMU request per handshake (accel x/y/z, gyro x/y/z, signed).
//   out_* : one result per request: raw face, stable face, jitter flag and
//           the accepted bit, in request order.
//   cfg_* : register write port, index 0..5, no wait state; indexes 6 and 7
//           are ignored. Write only while no request is in flight.
// Timing: a request is taken into an input register, evaluated in one pass
//   of compare and counter logic, and lands in the output register when the
//   output stage advances. Throughput is one request per cycle while
//   out_ready is high; the window, tally and stillness counters update
//   in the same cycle the result is registered.
// Stall: while out_ready is low a held result stays put; the input
//   register still takes one more request if it is empty, then in_ready drops.
// Reset: arst_n clears both pipeline valids, the counters, the gyro history
//   (to zero), the previous face (idle) and loads the register defaults.
module imu_orientation_jitter_qualifier (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  ioj_pkg::imu_sample_t              in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output ioj_pkg::imu_result_t              out_data,
	input  logic                              cfg_wr_en,
	input  logic [ioj_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [ioj_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import ioj_pkg::*;

	cfg_t        cfg_q;
	imu_sample_t smp_s1;
	logic        valid_s1;
	imu_result_t res_s2;
	logic        valid_s2;
	logic        advance;
	logic        fire;
	face_t       raw_face, stable_face;
	logic        jitter_flag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel_high_threshold <= RST_ACCEL_HIGH;
			cfg_q.accel_low_threshold  <= RST_ACCEL_LOW;
			cfg_q.jitter_threshold     <= RST_JITTER_THR;
			cfg_q.still_count_target   <= RST_STILL_TARGET;
			cfg_q.jitter_window        <= RST_JITTER_WIN;
			cfg_q.jitter_min_count     <= RST_JITTER_MIN;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_ACCEL_HIGH:   cfg_q.accel_high_threshold <= cfg_data[ACC_THR_W-1:0];
				CFG_ACCEL_LOW:    cfg_q.accel_low_threshold  <= cfg_data[ACC_THR_W-1:0];
				CFG_JITTER_THR:   cfg_q.jitter_threshold     <= cfg_data[JIT_THR_W-1:0];
				CFG_STILL_TARGET: cfg_q.still_count_target   <= cfg_data[COUNT_W-1:0];
				CFG_JITTER_WIN:   cfg_q.jitter_window        <= cfg_data[COUNT_W-1:0];
				CFG_JITTER_MIN:   cfg_q.jitter_min_count     <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance  = !valid_s2 || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			smp_s1 <= in_data;
	end

	ioj_jitter u_jitter (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (fire),
		.smp         (smp_s1),
		.cfg         (cfg_q),
		.jitter_flag (jitter_flag)
	);

	ioj_classify u_classify (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (fire),
		.smp         (smp_s1),
		.cfg         (cfg_q),
		.raw_face    (raw_face),
		.stable_face (stable_face)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2.raw_face    <= raw_face;
			res_s2.stable_face <= stable_face;
			res_s2.jitter_flag <= jitter_flag;
			res_s2.accepted    <= (stable_face != FACE_IDLE) && !jitter_flag;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

`ifndef SYNTHESIS
	a_accepted_rule: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (res_s2.accepted ==
			((res_s2.stable_face != FACE_IDLE) && !res_s2.jitter_flag)))
		else $error("accepted bit disagrees with stable face and jitter flag");

	a_stable_is_raw: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.stable_face != FACE_IDLE) |->
			(res_s2.stable_face == res_s2.raw_face))
		else $error("stable face differs from raw face");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(smp_s1)))
		else $error("input stage lost or changed a waiting request");

	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !valid_s1) |=> !valid_s2)
		else $error("result produced without a request in the input stage");
`endif

endmodule

// File: src/ioj_jitter.sv
// Windowed gyro jitter check: history, window counter, tally and flag.
// Depends on ioj_pkg.
module ioj_jitter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 upd,
	input  ioj_pkg::imu_sample_t smp,
	input  ioj_pkg::cfg_t        cfg,
	output logic                 jitter_flag
);
	import ioj_pkg::*;

	logic signed [GYRO_WIDTH-1:0] g [3];
	logic signed [GYRO_WIDTH-1:0] hist_q [3];
	logic signed [GDIFF_W-1:0]    diff [3];
	logic [GDIFF_W-1:0]           dmag [3];
	logic [2:0]                   axis_hit;
	logic                         win_open;
	logic [COUNT_W-1:0]           window_q, window_d;
	logic [COUNT_W-1:0]           tally_q, tally_d;
	logic                         flag_q, flag_d;

	assign g[0] = smp.gyro_x;
	assign g[1] = smp.gyro_y;
	assign g[2] = smp.gyro_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			// one bit of headroom so the difference never wraps
			diff[i] = GDIFF_W'(g[i]) - GDIFF_W'(hist_q[i]);
			dmag[i] = diff[i][GDIFF_W-1] ? GDIFF_W'(-diff[i]) : GDIFF_W'(diff[i]);
			axis_hit[i] = GCMP_W'(dmag[i]) > GCMP_W'(cfg.jitter_threshold);
		end
	end

	assign win_open = window_q < cfg.jitter_window;

	always_comb begin
		window_d = window_q;
		tally_d  = tally_q;
		flag_d   = flag_q;
		if (win_open) begin
			window_d = window_q + COUNT_W'(1);
			if (|axis_hit)
				tally_d = tally_q + COUNT_W'(1);
		end else begin
			// decision sample
			flag_d   = tally_q >= cfg.jitter_min_count;
			window_d = '0;
			tally_d  = '0;
		end
	end

	assign jitter_flag = flag_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			tally_q  <= '0;
			flag_q   <= 1'b0;
			for (int i = 0; i < 3; i++)
				hist_q[i] <= '0;
		end else if (upd) begin
			window_q <= window_d;
			tally_q  <= tally_d;
			flag_q   <= flag_d;
			for (int i = 0; i < 3; i++)
				hist_q[i] <= g[i];
		end
	end

endmodule

// File: src/ioj_classify.sv
// Gravity face classifier: magnitude thresholds and dominant axis sign.
// Depends on ioj_pkg.
module ioj_classify (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 upd,
	input  ioj_pkg::imu_sample_t smp,
	input  ioj_pkg::cfg_t        cfg,
	output ioj_pkg::face_t       raw_face,
	output ioj_pkg::face_t       stable_face
);
	import ioj_pkg::*;

	logic [ACCEL_WIDTH-1:0] mx, my, mz;
	logic [ACMP_W-1:0]      hi, lo;
	logic                   x_hi, y_hi, z_hi, x_lo, y_lo, z_lo;
	face_t                  face;

	// |v| fits ACCEL_WIDTH bits unsigned, including the most negative code
	assign mx = smp.accel_x[ACCEL_WIDTH-1] ? ACCEL_WIDTH'(-smp.accel_x) : smp.accel_x;
	assign my = smp.accel_y[ACCEL_WIDTH-1] ? ACCEL_WIDTH'(-smp.accel_y) : smp.accel_y;
	assign mz = smp.accel_z[ACCEL_WIDTH-1] ? ACCEL_WIDTH'(-smp.accel_z) : smp.accel_z;

	assign hi = ACMP_W'(cfg.accel_high_threshold);
	assign lo = ACMP_W'(cfg.accel_low_threshold);

	assign x_hi = ACMP_W'(mx) > hi;
	assign y_hi = ACMP_W'(my) > hi;
	assign z_hi = ACMP_W'(mz) > hi;
	assign x_lo = ACMP_W'(mx) < lo;
	assign y_lo = ACMP_W'(my) < lo;
	assign z_lo = ACMP_W'(mz) < lo;

	always_comb begin
		if (x_hi && y_lo && z_lo)
			face = smp.accel_x[ACCEL_WIDTH-1] ? FACE_FRONT : FACE_BACK;
		else if (x_lo && y_hi && z_lo)
			face = smp.accel_y[ACCEL_WIDTH-1] ? FACE_RIGHT : FACE_LEFT;
		else if (x_lo && y_lo && z_hi)
			face = (smp.accel_z > 0) ? FACE_UP : FACE_DOWN;
		else
			face = FACE_IDLE;
	end

	assign raw_face = face;

	ioj_still u_still (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (upd),
		.face        (face),
		.target      (cfg.still_count_target),
		.stable_face (stable_face)
	);

endmodule

// File: src/ioj_still.sv
// Stillness qualifier: repeat counter on the raw face, saturating at target.
// Depends on ioj_pkg.
module ioj_still (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          upd,
	input  ioj_pkg::face_t                face,
	input  logic [ioj_pkg::COUNT_W-1:0]   target,
	output ioj_pkg::face_t                stable_face
);
	import ioj_pkg::*;

	face_t              prev_q, prev_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [COUNT_W:0]   count_inc;

	assign count_inc = {1'b0, count_q} + (COUNT_W+1)'(1);

	always_comb begin
		prev_d      = prev_q;
		count_d     = count_q;
		stable_face = FACE_IDLE;
		if (face == prev_q && face != FACE_IDLE) begin
			if (count_inc >= {1'b0, target}) begin
				count_d     = target;
				stable_face = face;
			end else begin
				count_d = count_inc[COUNT_W-1:0];
			end
		end else begin
			count_d = '0;
			prev_d  = face;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= FACE_IDLE;
			count_q <= '0;
		end else if (upd) begin
			prev_q  <= prev_d;
			count_q <= count_d;
		end
	end

endmodule

// File: verif/tb.sv
// Self-checking testbench for imu_orientation_jitter_qualifier.
// Drives IMU requests through valid/ready with random idling and checks each result
// against an in-bench predictor. Depends on ioj_pkg and the RTL under src/.
module tb;
	import ioj_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 3'd7;
	localparam int NUM_PHASES = 9;

	typedef struct {
		int    ax, ay, az, gx, gy, gz;
		bit    typed;
		face_t raw, stable;
		bit    jit, acc;
	} opening_row_t;

	// extremes of every field and each face; outcome typed where it is obvious
	const opening_row_t opening_rows [14] = '{
		'{0, 0, 0, 0, 0, 0, 1, FACE_IDLE, FACE_IDLE, 0, 0},
		'{32767, 0, 0, 0, 0, 0, 1, FACE_BACK, FACE_IDLE, 0, 0},
		'{-32768, 0, 0, 0, 0, 0, 1, FACE_FRONT, FACE_IDLE, 0, 0},
		'{0, -32768, 0, 0, 0, 0, 1, FACE_RIGHT, FACE_IDLE, 0, 0},
		'{0, 32767, 0, 0, 0, 0, 1, FACE_LEFT, FACE_IDLE, 0, 0},
		'{0, 0, 32767, 0, 0, 0, 1, FACE_UP, FACE_IDLE, 0, 0},
		'{0, 0, -32768, 0, 0, 0, 1, FACE_DOWN, FACE_IDLE, 0, 0},
		'{8801, 1999, -1999, 0, 0, 0, 1, FACE_BACK, FACE_IDLE, 0, 0},
		'{8800, 0, 0, 0, 0, 0, 1, FACE_IDLE, FACE_IDLE, 0, 0},
		'{9000, 2000, 0, 0, 0, 0, 1, FACE_IDLE, FACE_IDLE, 0, 0},
		'{0, 0, 9000, 32767, -32768, 32767, 1, FACE_UP, FACE_IDLE, 0, 0},
		'{0, 0, 9000, -32768, 32767, -32768, 0, FACE_UP, FACE_IDLE, 0, 0},
		'{-1, 1, 9001, -1, -1, -1, 0, FACE_UP, FACE_IDLE, 0, 0},
		'{-1999, -1999, -8801, 0, 0, 0, 0, FACE_DOWN, FACE_IDLE, 0, 0}
	};

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	imu_sample_t            in_data;
	logic                   out_valid;
	logic                   out_ready;
	imu_result_t            out_data;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// predictor registers
	int acc_hi, acc_lo, jit_thr, still_tgt, jit_win, jit_min;
	// predictor state
	face_t prev_face;
	int    repeat_cnt, win_cnt, tally;
	int    gyro_hist [3];
	bit    jit_state;

	imu_result_t expected_results [$];
	int          mismatches;
	int          results_seen;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          gyro_now [3];

	imu_orientation_jitter_qualifier u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3000000;
		$display("tb: failure");
		$finish;
	end

	function automatic face_t classify_face(input int ax, input int ay, input int az);
		int mx, my, mz;
		mx = (ax < 0) ? -ax : ax;
		my = (ay < 0) ? -ay : ay;
		mz = (az < 0) ? -az : az;
		if (mx > acc_hi && my < acc_lo && mz < acc_lo)
			return (ax < 0) ? FACE_FRONT : FACE_BACK;
		if (mx < acc_lo && my > acc_hi && mz < acc_lo)
			return (ay < 0) ? FACE_RIGHT : FACE_LEFT;
		if (mx < acc_lo && my < acc_lo && mz > acc_hi)
			return (az > 0) ? FACE_UP : FACE_DOWN;
		return FACE_IDLE;
	endfunction

	// advances the jitter window and stillness state by one request
	function automatic imu_result_t qualify_sample(input imu_sample_t s);
		int          g [3];
		int          k, d, nxt;
		bit          hit;
		face_t       f, stable;
		imu_result_t r;
		g[0] = s.gyro_x;
		g[1] = s.gyro_y;
		g[2] = s.gyro_z;
		if (win_cnt < jit_win) begin
			win_cnt++;
			hit = 1'b0;
			for (k = 0; k < 3; k++) begin
				d = g[k] - gyro_hist[k];
				if (d < 0)
					d = -d;
				if (d > jit_thr)
					hit = 1'b1;
			end
			if (hit)
				tally = (tally + 1) & 255;
		end else begin
			jit_state = (tally >= jit_min);
			win_cnt = 0;
			tally = 0;
		end
		gyro_hist = g;

		f = classify_face(s.accel_x, s.accel_y, s.accel_z);
		stable = FACE_IDLE;
		if (f == prev_face && f != FACE_IDLE) begin
			nxt = repeat_cnt + 1;
			if (nxt >= still_tgt) begin
				repeat_cnt = still_tgt;
				stable = f;
			end else begin
				repeat_cnt = nxt;
			end
		end else begin
			repeat_cnt = 0;
			prev_face = f;
		end
		r.raw_face = f;
		r.stable_face = stable;
		r.jitter_flag = jit_state;
		r.accepted = (stable != FACE_IDLE) && !jit_state;
		return r;
	endfunction

	// accel part of a request aimed at the given face under current thresholds
	function automatic imu_sample_t face_sample(input face_t f);
		imu_sample_t s;
		int          a [3];
		int          k, dom, pos;
		for (k = 0; k < 3; k++)
			a[k] = (acc_lo > 0) ? int'($urandom_range(2 * acc_lo - 2)) - (acc_lo - 1) : 0;
		dom = (acc_hi < 32767) ? int'($urandom_range(32767, acc_hi + 1)) : 32768;
		pos = (dom > 32767) ? 32767 : dom;
		case (f)
			FACE_UP:    a[2] = pos;
			FACE_DOWN:  a[2] = -dom;
			FACE_LEFT:  a[1] = pos;
			FACE_RIGHT: a[1] = -dom;
			FACE_FRONT: a[0] = -dom;
			FACE_BACK:  a[0] = pos;
			default: ;
		endcase
		s = '0;
		s.accel_x = ACCEL_WIDTH'(a[0]);
		s.accel_y = ACCEL_WIDTH'(a[1]);
		s.accel_z = ACCEL_WIDTH'(a[2]);
		return s;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < 40)
			$display("tb: mismatch at result %0d: %s", results_seen, msg);
		mismatches++;
	endtask

	task automatic push_sample(input imu_sample_t s, input bit typed, input imu_result_t want);
		imu_result_t pred;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= s;
		do
			@(posedge clk);
		while (!in_ready);
		pred = qualify_sample(s);
		expected_results.push_back(typed ? want : pred);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_ACCEL_HIGH:   acc_hi = val[ACC_THR_W-1:0];
			CFG_ACCEL_LOW:    acc_lo = val[ACC_THR_W-1:0];
			CFG_JITTER_THR:   jit_thr = val[JIT_THR_W-1:0];
			CFG_STILL_TARGET: still_tgt = val[COUNT_W-1:0];
			CFG_JITTER_WIN:   jit_win = val[COUNT_W-1:0];
			CFG_JITTER_MIN:   jit_min = val[COUNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(input logic [15:0] hi, input logic [15:0] lo,
			input logic [15:0] jthr, input logic [15:0] tgt, input logic [15:0] win,
			input logic [15:0] minc);
		write_reg(CFG_ACCEL_HIGH, hi);
		write_reg(CFG_SPARE_A, 16'($urandom));
		write_reg(CFG_ACCEL_LOW, lo);
		write_reg(CFG_JITTER_THR, jthr);
		write_reg(CFG_STILL_TARGET, tgt);
		write_reg(CFG_JITTER_WIN, win);
		write_reg(CFG_JITTER_MIN, minc);
		write_reg(CFG_SPARE_B, 16'($urandom));
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// runs of one face with quiet or jittery gyro, plus scrambled bursts
	task automatic drive_random(input int n);
		int          sent, run_len, jit_pct, i, k, v, q;
		bit          scrambled, jittery;
		face_t       f;
		imu_sample_t s;
		sent = 0;
		while (sent < n) begin
			scrambled = ($urandom_range(99) < 12);
			f = face_t'($urandom_range(6));
			run_len = scrambled ? $urandom_range(3, 1) : $urandom_range(still_tgt + 3, 1);
			case ($urandom_range(2))
				0: jit_pct = 0;
				1: jit_pct = 25;
				default: jit_pct = 80;
			endcase
			for (i = 0; i < run_len && sent < n; i++) begin
				if (scrambled) begin
					s = {$urandom, $urandom, $urandom};
					gyro_now[0] = s.gyro_x;
					gyro_now[1] = s.gyro_y;
					gyro_now[2] = s.gyro_z;
				end else begin
					// an odd request breaks the run now and then
					s = face_sample(($urandom_range(99) < 8) ? face_t'($urandom_range(6)) : f);
					q = jit_thr / 2;
					jittery = ($urandom_range(99) < jit_pct);
					for (k = 0; k < 3; k++) begin
						if (jittery)
							v = int'($urandom_range(65535)) - 32768;
						else
							v = gyro_now[k] + int'($urandom_range(2 * q)) - q;
						gyro_now[k] = (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
					end
					s.gyro_x = GYRO_WIDTH'(gyro_now[0]);
					s.gyro_y = GYRO_WIDTH'(gyro_now[1]);
					s.gyro_z = GYRO_WIDTH'(gyro_now[2]);
				end
				push_sample(s, 1'b0, '0);
				sent++;
			end
		end
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		imu_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				want = expected_results.pop_front();
				if (out_data.raw_face !== want.raw_face)
					report_mismatch($sformatf("raw_face %0d, want %0d",
						out_data.raw_face, want.raw_face));
				if (out_data.stable_face !== want.stable_face)
					report_mismatch($sformatf("stable_face %0d, want %0d",
						out_data.stable_face, want.stable_face));
				if (out_data.jitter_flag !== want.jitter_flag)
					report_mismatch($sformatf("jitter_flag %0b, want %0b",
						out_data.jitter_flag, want.jitter_flag));
				if (out_data.accepted !== want.accepted)
					report_mismatch($sformatf("accepted %0b, want %0b",
						out_data.accepted, want.accepted));
			end
			results_seen++;
		end
	end

	initial begin
		int          p, r, junk, hi_r, lo_r, jthr_r, tgt_r, win_r, min_r;
		imu_sample_t s;
		imu_result_t want;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		results_seen = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		gyro_now = '{0, 0, 0};
		acc_hi = RST_ACCEL_HIGH;
		acc_lo = RST_ACCEL_LOW;
		jit_thr = RST_JITTER_THR;
		still_tgt = RST_STILL_TARGET;
		jit_win = RST_JITTER_WIN;
		jit_min = RST_JITTER_MIN;
		prev_face = FACE_IDLE;
		repeat_cnt = 0;
		win_cnt = 0;
		tally = 0;
		gyro_hist = '{0, 0, 0};
		jit_state = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (p = 0; p < NUM_PHASES; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
				default: begin send_idle_pct = 11; recv_stall_pct = 11; end
			endcase
			if (p != 0) begin
				// registers only change with no request in flight
				while (expected_results.size() != 0)
					@(posedge clk);
				repeat (4) @(posedge clk);
				case (p)
					1: load_settings(16'h8000 | 16'd5000, 16'h8000 | 16'd3000, 16'd300,
						16'hFF04, 16'h0108, 16'd3);
					// zero target, zero window and zero minimum together
					2: load_settings(16'd8800, 16'd2000, 16'd800, 16'd0, 16'd0, 16'd0);
					3: load_settings(16'h7FFF, 16'h7FFF, 16'd0, 16'd1, 16'd1, 16'd0);
					4: load_settings(16'd0, 16'd0, 16'hFFFF, 16'd255, 16'd255, 16'd255);
					5: load_settings(16'd0, 16'h7FFF, 16'd0, 16'd255, 16'd255, 16'd255);
					6: load_settings(16'd15000, 16'd1000, 16'd2000, 16'd12, 16'd30, 16'd10);
					default: begin
						junk = $urandom;
						hi_r = $urandom_range(20000, 1000);
						lo_r = $urandom_range(4000, 200);
						jthr_r = $urandom_range(4000);
						tgt_r = $urandom_range(16, 1);
						win_r = $urandom_range(40);
						min_r = $urandom_range(20);
						load_settings({junk[0], hi_r[14:0]}, {junk[1], lo_r[14:0]},
							jthr_r[15:0], {junk[15:8], tgt_r[7:0]},
							{junk[23:16], win_r[7:0]}, {junk[31:24], min_r[7:0]});
					end
				endcase
			end
			if (p == 0) begin
				for (r = 0; r < $size(opening_rows); r++) begin
					s.accel_x = ACCEL_WIDTH'(opening_rows[r].ax);
					s.accel_y = ACCEL_WIDTH'(opening_rows[r].ay);
					s.accel_z = ACCEL_WIDTH'(opening_rows[r].az);
					s.gyro_x = GYRO_WIDTH'(opening_rows[r].gx);
					s.gyro_y = GYRO_WIDTH'(opening_rows[r].gy);
					s.gyro_z = GYRO_WIDTH'(opening_rows[r].gz);
					want.raw_face = opening_rows[r].raw;
					want.stable_face = opening_rows[r].stable;
					want.jitter_flag = opening_rows[r].jit;
					want.accepted = opening_rows[r].acc;
					push_sample(s, opening_rows[r].typed, want);
				end
			end
			drive_random((p == 4) ? 60 : 200);
			@(negedge clk);
			in_valid <= 1'b0;
		end

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
